FILE: sv/assert_macros.svh
// Shared assertion macros for the RTL folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication in the same cycle; ignored while reset is high.
`define POSL_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define POSL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/posl_pkg.sv
`default_nettype none

package posl_pkg;

   localparam int OPCODE_W = 2;
   localparam int POS_W    = 7;
   localparam int COLOR_W  = 3;
   localparam int VALUE_W  = 8;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;
   localparam int FIDX_W   = 6;
   localparam int ECNT_W   = 7;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

   // Stored entry, packed kind:value:color.
   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
      logic [COLOR_W-1:0]        color;
   } card_type;

   // Controller to datapath.
   typedef struct packed {
      logic                take;
      logic                ld_run;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                step;
      logic                commit_ins;
      logic                commit_rem;
      logic                publish;
   } posl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                ins_bad;
      logic                full;
      logic                rem_bad;
      logic                left_zero;
   } posl_stat_type;

endpackage

`default_nettype wire

FILE: sv/posl_req_if.sv
`default_nettype none

interface posl_req_if;
   import posl_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OPCODE_W-1:0]       opcode;
   logic [POS_W-1:0]          position;
   logic [COLOR_W-1:0]        card_color;
   logic signed [VALUE_W-1:0] card_value;
   logic [KIND_W-1:0]         card_kind;

   modport source (
      output valid, opcode, position, card_color, card_value, card_kind,
      input  ready
   );
   modport sink (
      input  valid, opcode, position, card_color, card_value, card_kind,
      output ready
   );
endinterface

`default_nettype wire

FILE: sv/posl_rsp_if.sv
`default_nettype none

interface posl_rsp_if;
   import posl_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic                      found;
   logic [FIDX_W-1:0]         found_index;
   logic [COLOR_W-1:0]        out_color;
   logic signed [VALUE_W-1:0] out_value;
   logic [KIND_W-1:0]         out_kind;
   logic [ECNT_W-1:0]         entry_count;

   modport source (
      output valid, status, found, found_index, out_color, out_value, out_kind,
             entry_count,
      input  ready
   );
   modport sink (
      input  valid, status, found, found_index, out_color, out_value, out_kind,
             entry_count,
      output ready
   );
endinterface

`default_nettype wire

FILE: sv/positional_ordered_list.sv
// Flow: insert and remove walk (count - position) entries, search walks count entries;
//   a rejected request skips the walk and goes straight to the response.
// Throughput: one request at a time, walking the entry memory one entry per cycle;
//   the next request is accepted only after the response has been published.
// Reset: count goes to zero and the response register empties; entry memory
//   contents are left as they are and need no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module positional_ordered_list #(
   parameter int CAPACITY = 64
) (
   input wire logic     clock,
   input wire logic     reset,
   posl_req_if.sink     req_ch,
   posl_rsp_if.source   rsp_ch
);
   import posl_pkg::*;

   posl_cmd_type        cmd;
   posl_stat_type       stat;
   card_type            in_card;
   logic                out_free;

   logic [STATUS_W-1:0] res_status;
   logic                res_found;
   logic [FIDX_W-1:0]   res_fidx;
   card_type            res_card;
   logic [ECNT_W-1:0]   res_count;

   // Response register: holds a finished result while the sink stalls.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_found_ff;
   logic [FIDX_W-1:0]   rsp_fidx_ff;
   card_type            rsp_card_ff;
   logic [ECNT_W-1:0]   rsp_count_ff;

   // Pack the request card as stored.
   always_comb begin
      in_card.kind  = req_ch.card_kind;
      in_card.value = req_ch.card_value;
      in_card.color = req_ch.card_color;
   end

   // The register may take a new result when empty or draining this cycle.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   posl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .out_free  (out_free),
      .cmd       (cmd)
   );

   posl_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .in_opcode   (req_ch.opcode),
      .in_position (req_ch.position),
      .in_card     (in_card),
      .res_status  (res_status),
      .res_found   (res_found),
      .res_fidx    (res_fidx),
      .res_card    (res_card),
      .res_count   (res_count)
   );

   // Hold valid until the sink takes the response; load on publish.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_status_ff <= res_status;
         rsp_found_ff  <= res_found;
         rsp_fidx_ff   <= res_fidx;
         rsp_card_ff   <= res_card;
         rsp_count_ff  <= res_count;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.found_index = rsp_fidx_ff;
   assign rsp_ch.out_color   = rsp_card_ff.color;
   assign rsp_ch.out_value   = rsp_card_ff.value;
   assign rsp_ch.out_kind    = rsp_card_ff.kind;
   assign rsp_ch.entry_count = rsp_count_ff;

   `POSL_ASSERT_NEXT(a_publish_valid, clock, reset, cmd.publish, rsp_ch.valid,
      "published response not presented")
   `POSL_ASSERT(a_publish_free, clock, reset, cmd.publish |-> out_free,
      "response overwritten before it was taken")
   `POSL_ASSERT_NEXT(a_one_request, clock, reset, req_ch.valid && req_ch.ready,
      !req_ch.ready, "second request taken while one is in flight")

endmodule

`default_nettype wire

FILE: sv/posl_dp.sv
`default_nettype none
`include "assert_macros.svh"

module posl_dp #(
   parameter int CAPACITY = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire posl_pkg::posl_cmd_type             cmd,
   output      posl_pkg::posl_stat_type            stat,
   input  wire logic [posl_pkg::OPCODE_W-1:0]      in_opcode,
   input  wire logic [posl_pkg::POS_W-1:0]         in_position,
   input  wire posl_pkg::card_type                 in_card,
   output      logic [posl_pkg::STATUS_W-1:0]      res_status,
   output      logic                               res_found,
   output      logic [posl_pkg::FIDX_W-1:0]        res_fidx,
   output      posl_pkg::card_type                 res_card,
   output      logic [posl_pkg::ECNT_W-1:0]        res_count
);
   import posl_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   card_type            mem_q [CAPACITY];

   logic [OPCODE_W-1:0] opcode_ff;
   logic [POS_W-1:0]    pos_ff;
   card_type            card_ff;
   logic [CW-1:0]       count_ff;
   logic [AW-1:0]       rd_ptr_ff;
   logic [CW-1:0]       left_ff;
   logic                first_ff;
   logic                pend_wr_ff;
   logic                pend_cap_ff;
   logic                pend_cmp_ff;
   logic [AW-1:0]       pend_addr_ff;
   card_type            rdata_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                found_ff;
   logic [FIDX_W-1:0]   fidx_ff;
   card_type            out_card_ff;

   logic [XW-1:0]       pos_x;
   logic [XW-1:0]       cnt_x;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   card_type            mem_wdata;

   assign pos_x = XW'(pos_ff);
   assign cnt_x = XW'(count_ff);

   always_comb begin
      stat.opcode    = opcode_ff;
      stat.ins_bad   = pos_x > cnt_x;
      stat.full      = count_ff == CW'(CAPACITY);
      stat.rem_bad   = pos_x >= cnt_x;
      stat.left_zero = left_ff == '0;
   end

   // Shift writes land in the cycle after their read; the new card lands after the walk.
   always_comb begin
      mem_we    = pend_wr_ff || cmd.commit_ins;
      mem_waddr = cmd.commit_ins ? AW'(pos_ff) : pend_addr_ff;
      mem_wdata = cmd.commit_ins ? card_ff : rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_q[mem_waddr] <= mem_wdata;
      end
      if (cmd.step) begin
         rdata_ff <= mem_q[rd_ptr_ff];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         left_ff     <= '0;
         pend_wr_ff  <= 1'b0;
         pend_cap_ff <= 1'b0;
         pend_cmp_ff <= 1'b0;
      end else begin
         pend_wr_ff  <= cmd.step && (opcode_ff == OP_INSERT ||
                                     (opcode_ff == OP_REMOVE && !first_ff));
         pend_cap_ff <= cmd.step && opcode_ff == OP_REMOVE && first_ff;
         pend_cmp_ff <= cmd.step && opcode_ff != OP_INSERT && opcode_ff != OP_REMOVE;
         if (cmd.commit_ins) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.commit_rem) begin
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.ld_run) begin
            case (opcode_ff)
               OP_INSERT: left_ff <= count_ff - CW'(pos_ff);
               OP_REMOVE: left_ff <= count_ff - CW'(pos_ff);
               default:   left_ff <= count_ff;
            endcase
         end else if (cmd.step) begin
            left_ff <= left_ff - CW'(1);
         end
      end
   end

   // Request, walk pointer and result fields.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         opcode_ff   <= in_opcode;
         pos_ff      <= in_position;
         card_ff     <= in_card;
         status_ff   <= ST_OK;
         found_ff    <= 1'b0;
         fidx_ff     <= '0;
         out_card_ff <= '0;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.ld_run) begin
         first_ff <= 1'b1;
         case (opcode_ff)
            OP_INSERT: rd_ptr_ff <= AW'(count_ff - CW'(1));
            OP_REMOVE: rd_ptr_ff <= AW'(pos_ff);
            default:   rd_ptr_ff <= '0;
         endcase
      end else if (cmd.step) begin
         first_ff <= 1'b0;
         case (opcode_ff)
            OP_INSERT: begin
               rd_ptr_ff    <= rd_ptr_ff - AW'(1);
               pend_addr_ff <= rd_ptr_ff + AW'(1);
            end
            OP_REMOVE: begin
               rd_ptr_ff    <= rd_ptr_ff + AW'(1);
               pend_addr_ff <= rd_ptr_ff - AW'(1);
            end
            default: begin
               rd_ptr_ff    <= rd_ptr_ff + AW'(1);
               pend_addr_ff <= rd_ptr_ff;
            end
         endcase
      end
      if (pend_cap_ff) begin
         out_card_ff <= rdata_ff;
      end
      if (pend_cmp_ff && !found_ff && rdata_ff == card_ff) begin
         found_ff <= 1'b1;
         fidx_ff  <= FIDX_W'(pend_addr_ff);
      end
   end

   assign res_status = status_ff;
   assign res_found  = found_ff;
   assign res_fidx   = fidx_ff;
   assign res_card   = out_card_ff;
   assign res_count  = ECNT_W'(count_ff);

   `POSL_ASSERT(a_ins_not_full, clock, reset, cmd.commit_ins |-> !stat.full,
      "insert committed into a full store")
   `POSL_ASSERT(a_rem_not_empty, clock, reset, cmd.commit_rem |-> count_ff != '0,
      "remove committed on an empty store")
   `POSL_ASSERT(a_step_in_range, clock, reset, cmd.step |-> !stat.left_zero,
      "walk stepped past its range")

endmodule

`default_nettype wire

FILE: sv/posl_ctrl.sv
`default_nettype none

module posl_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire posl_pkg::posl_stat_type stat,
   input  wire logic                    out_free,
   output      posl_pkg::posl_cmd_type  cmd
);
   import posl_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      DECIDE,
      RUN,
      DRAIN,
      FINISH,
      DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            cmd.take = req_valid && ready_ff;
            if (cmd.take) begin
               state_in = DECIDE;
            end
         end
         DECIDE: begin
            case (stat.opcode)
               OP_INSERT: begin
                  if (stat.ins_bad) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_BADPOS;
                  end else if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_FULL;
                  end else begin
                     cmd.ld_run = 1'b1;
                  end
               end
               OP_REMOVE: begin
                  if (stat.rem_bad) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_BADPOS;
                  end else begin
                     cmd.ld_run = 1'b1;
                  end
               end
               OP_SEARCH: cmd.ld_run = 1'b1;
               default: begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_BADPOS;
               end
            endcase
            state_in = cmd.ld_run ? RUN : DONE;
         end
         RUN: begin
            cmd.step = !stat.left_zero;
            if (stat.left_zero) begin
               state_in = DRAIN;
            end
         end
         DRAIN: state_in = FINISH;
         FINISH: begin
            cmd.commit_ins = stat.opcode == OP_INSERT;
            cmd.commit_rem = stat.opcode == OP_REMOVE;
            state_in       = DONE;
         end
         DONE: begin
            cmd.publish = out_free;
            if (out_free) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.take) begin
            ready_ff <= 1'b0;
         end else if (state_in == IDLE) begin
            ready_ff <= 1'b1;
         end
      end
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire
